// ----- rtl/core/mfdep_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI drum event parser package
// Shared types and constants for the parser and its wait-time divider.
// ----------------------------------------------------------------------------
package mfdep_pkg;

  localparam logic [3:0]  DrumChanReset  = 4'd9;
  localparam logic [31:0] TagHeader      = 32'h4D546864;
  localparam logic [31:0] TagTrack       = 32'h4D54726B;
  localparam logic [7:0]  MetaEndTrack   = 8'h2F;
  localparam logic [7:0]  MetaTempo      = 8'h51;
  localparam logic [31:0] TempoReset     = 32'd500000;
  localparam logic [14:0] DivisionReset  = 15'd480;
  localparam logic [9:0]  MsPerSec       = 10'd1000;
  localparam logic [7:0]  SysExStart     = 8'hF0;
  localparam logic [7:0]  SysExEscape    = 8'hF7;
  localparam logic [7:0]  MetaStatus     = 8'hFF;
  localparam logic [3:0]  NoteOnHi       = 4'h9;
  localparam logic [27:0] Mask28         = 28'h0FFFFFFF;

  typedef enum logic [1:0] {
    KIND_HIT   = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // Request to the divider: dividend and divisor (division times 1000).
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [24:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/midi_file_drum_event_parser.sv -----
// ----------------------------------------------------------------------------
// MIDI file drum event parser
// Byte-serial Standard MIDI File walker reporting drum hits, waits, song end
// and format errors.
// ----------------------------------------------------------------------------
// Timing: a wait word passes a registered product, divider load, 32 divide
//   steps and the output register after its last delta byte.
// Throughput: one byte per cycle; a nonzero delta with a nonzero division holds
//   the input until its wait word is out, and a word left unread in the output register holds it too.
// Reset: asynchronous, active low; header tag, tempo 500000 us, division 480,
//   drum channel 9.
module midi_file_drum_event_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,     // drum_channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] file_byte
  input  logic        s_axis_tuser,    // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,    // [7:0] note_number, [15:8] velocity,
                                       // [47:16] wait_ms, [48] frame_mode
  output logic [1:0]  m_axis_tuser     // [1:0] kind
);
  import mfdep_pkg::*;

  typedef enum logic [4:0] {
    ST_HDR_TAG, ST_HDR_LEN, ST_HDR_FMT, ST_HDR_NTRK, ST_HDR_DIV, ST_HDR_SKIP,
    ST_TRK_TAG, ST_TRK_LEN, ST_DELTA, ST_EVENT, ST_DATA1, ST_DATA2,
    ST_META_TYPE, ST_LEN_SKIP, ST_LEN_TEMPO, ST_SKIP, ST_TEMPO, ST_EOT_LEN,
    ST_DONE, ST_MUL, ST_DIV
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] shift_q, shift_d;
  logic [27:0] left_q, left_d;
  logic [31:0] delta_q, delta_d;
  logic [31:0] tempo_q, tempo_d;
  logic [14:0] div_q, div_d;
  logic        frames_q, frames_d;
  logic [15:0] ntrk_q, ntrk_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  rs_q, rs_d;
  logic [7:0]  held_q, held_d;
  logic [2:0]  bcnt_q, bcnt_d;
  logic [3:0]  chan_q;
  logic [31:0] prod_q;

  logic        ov_q;
  logic [1:0]  okind_q;
  logic [7:0]  onote_q, ovel_q;
  logic [31:0] owait_q;
  logic        oframe_q;

  logic        emit;
  kind_e       ekind;
  logic [7:0]  enote, evel;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [24:0] dsr_ms;

  logic        take;
  logic [7:0]  b;
  logic [31:0] sh8, sh7;
  logic [2:0]  bcnt_inc;
  logic        one_db;

  mfdep_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Hold input while busy with a wait or while a word sits unread.
  assign s_axis_tready = (state_q != ST_MUL) && (state_q != ST_DIV) &&
                         (!ov_q || m_axis_tready);
  assign take     = s_axis_tvalid && s_axis_tready;
  assign b        = s_axis_tdata;
  assign sh8      = {shift_q[23:0], b};
  assign sh7      = {shift_q[24:0], b[6:0]};
  assign bcnt_inc = bcnt_q + 3'd1;
  assign one_db   = (rs_q[7:4] == 4'hC) || (rs_q[7:4] == 4'hD);

  // Fold both truncating divisions into one: divide by division times 1000.
  assign dsr_ms        = {10'd0, div_q} * {15'd0, MsPerSec};
  assign dreq.start    = (state_q == ST_MUL);
  assign dreq.dividend = prod_q;
  assign dreq.divisor  = dsr_ms;

  always_comb begin
    state_d = state_q; shift_d = shift_q; left_d = left_q; delta_d = delta_q;
    tempo_d = tempo_q; div_d = div_q; frames_d = frames_q; ntrk_d = ntrk_q;
    seen_d = seen_q; rs_d = rs_q; held_d = held_q; bcnt_d = bcnt_q;
    emit = 1'b0; ekind = KIND_HIT; enote = '0; evel = '0;
    if (state_q == ST_DIV) begin
      if (drsp.done) begin
        state_d = ST_EVENT;
        emit    = 1'b1;
        ekind   = KIND_WAIT;
      end
    end else if (take && s_axis_tuser) begin
      // restart: clear all parse state
      state_d = ST_HDR_TAG; shift_d = '0; left_d = '0; delta_d = '0;
      tempo_d = TempoReset; div_d = DivisionReset; frames_d = 1'b0;
      ntrk_d = '0; seen_d = '0; rs_d = '0; held_d = '0; bcnt_d = '0;
    end else if (take) begin
      case (state_q)
        ST_HDR_TAG, ST_TRK_TAG, ST_HDR_LEN, ST_TRK_LEN: begin
          shift_d = sh8;
          bcnt_d  = bcnt_inc;
          if (bcnt_inc >= 3'd4) begin
            bcnt_d  = '0;
            shift_d = '0;
            case (state_q)
              ST_HDR_TAG: begin
                if (sh8 == TagHeader) state_d = ST_HDR_LEN;
                else begin
                  state_d = ST_DONE; emit = 1'b1; ekind = KIND_ERROR;
                end
              end
              ST_TRK_TAG: begin
                if (sh8 == TagTrack) begin
                  if (seen_q != 16'hFFFF) seen_d = seen_q + 16'd1;
                  rs_d = '0; held_d = '0; state_d = ST_TRK_LEN;
                end else begin
                  state_d = ST_DONE; emit = 1'b1; ekind = KIND_ERROR;
                end
              end
              ST_HDR_LEN: begin
                if (sh8 <= 32'd6) left_d = '0;
                else if (sh8 - 32'd6 > {4'd0, Mask28}) left_d = Mask28;
                else left_d = 28'(sh8 - 32'd6);
                state_d = ST_HDR_FMT;
              end
              default: begin
                delta_d = '0; state_d = ST_DELTA;
              end
            endcase
          end
        end
        ST_HDR_FMT, ST_HDR_NTRK, ST_HDR_DIV: begin
          shift_d = sh8;
          bcnt_d  = bcnt_inc;
          if (bcnt_inc >= 3'd2) begin
            bcnt_d  = '0;
            shift_d = '0;
            case (state_q)
              ST_HDR_FMT:  state_d = ST_HDR_NTRK;
              ST_HDR_NTRK: begin
                ntrk_d = sh8[15:0]; state_d = ST_HDR_DIV;
              end
              default: begin
                frames_d = sh8[15];
                div_d    = sh8[14:0];
                state_d  = (left_q != '0) ? ST_HDR_SKIP : ST_TRK_TAG;
              end
            endcase
          end
        end
        ST_HDR_SKIP: begin
          left_d = left_q - 28'd1;
          if (left_d == '0) state_d = ST_TRK_TAG;
        end
        ST_DELTA: begin
          delta_d = {delta_q[24:0], b[6:0]};
          if (!b[7]) begin
            state_d = ST_EVENT;
            if (delta_d != '0) begin
              if (div_q == '0) begin
                emit = 1'b1; ekind = KIND_WAIT;
              end else begin
                state_d = ST_MUL;
              end
            end
          end
        end
        ST_EVENT: begin
          if (b == SysExStart || b == SysExEscape) begin
            shift_d = '0; state_d = ST_LEN_SKIP;
          end else if (b == MetaStatus) begin
            state_d = ST_META_TYPE;
          end else if (b[7]) begin
            if (b < SysExStart) begin
              rs_d = b; held_d = '0; state_d = ST_DATA1;
            end
          end else if (rs_q != '0) begin
            if (one_db) begin
              delta_d = '0; state_d = ST_DELTA;
            end else begin
              held_d = b; state_d = ST_DATA2;
            end
          end
        end
        ST_DATA1: begin
          if (one_db) begin
            delta_d = '0; state_d = ST_DELTA;
          end else begin
            held_d = b; state_d = ST_DATA2;
          end
        end
        ST_DATA2: begin
          delta_d = '0; state_d = ST_DELTA;
          if (rs_q[7:4] == NoteOnHi && rs_q[3:0] == chan_q && b != '0) begin
            emit = 1'b1; ekind = KIND_HIT; enote = held_q; evel = b;
          end
        end
        ST_META_TYPE: begin
          shift_d = '0;
          if (b == MetaEndTrack) begin
            if (seen_q >= ntrk_q) begin
              state_d = ST_DONE; emit = 1'b1; ekind = KIND_END;
            end else state_d = ST_EOT_LEN;
          end else state_d = (b == MetaTempo) ? ST_LEN_TEMPO : ST_LEN_SKIP;
        end
        ST_LEN_SKIP, ST_LEN_TEMPO: begin
          shift_d = sh7;
          if (!b[7]) begin
            left_d  = sh7[27:0];
            shift_d = '0;
            if (sh7[27:0] != '0) begin
              state_d = (state_q == ST_LEN_TEMPO) ? ST_TEMPO : ST_SKIP;
            end else begin
              if (state_q == ST_LEN_TEMPO) tempo_d = '0;
              delta_d = '0; state_d = ST_DELTA;
            end
          end
        end
        ST_SKIP: begin
          left_d = left_q - 28'd1;
          if (left_d == '0) begin
            delta_d = '0; state_d = ST_DELTA;
          end
        end
        ST_TEMPO: begin
          shift_d = sh8;
          left_d  = left_q - 28'd1;
          if (left_d == '0) begin
            tempo_d = sh8; shift_d = '0; delta_d = '0; state_d = ST_DELTA;
          end
        end
        ST_EOT_LEN: begin
          bcnt_d = '0; shift_d = '0; state_d = ST_TRK_TAG;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HDR_TAG; shift_q <= '0; left_q <= '0; delta_q <= '0;
      tempo_q <= TempoReset; div_q <= DivisionReset; frames_q <= 1'b0;
      ntrk_q <= '0; seen_q <= '0; rs_q <= '0; held_q <= '0; bcnt_q <= '0;
      chan_q <= DrumChanReset; ov_q <= 1'b0;
    end else begin
      shift_q <= shift_d; left_q <= left_d; tempo_q <= tempo_d;
      div_q <= div_d; frames_q <= frames_d; ntrk_q <= ntrk_d; seen_q <= seen_d;
      rs_q <= rs_d; held_q <= held_d; bcnt_q <= bcnt_d; delta_q <= delta_d;
      if (cfg_we_i) chan_q <= cfg_wdata_i;
      // step the wait sequencer: register product, then hand to divider
      case (state_q)
        ST_MUL: begin
          state_q <= ST_DIV;
        end
        default: state_q <= state_d;
      endcase
      if (state_d == ST_MUL) prod_q <= 32'(tempo_q * delta_d);
      if (emit) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (emit) begin
      okind_q  <= ekind;
      onote_q  <= enote;
      ovel_q   <= evel;
      owait_q  <= (ekind == KIND_WAIT && div_q != '0) ? drsp.quotient : '0;
      oframe_q <= frames_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tdata  = {7'd0, oframe_q, owait_q, ovel_q, onote_q};

  // A finished quotient always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |=> m_axis_tvalid) else $error("divider result lost");

  // Input is held while the divider works.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.busy |-> !s_axis_tready) else $error("input taken during divide");

  // A divider start is always followed by the divide state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |=> state_q == ST_DIV) else $error("divide sequencer slip");

endmodule

// ----- rtl/core/mfdep_divider.sv -----
// ----------------------------------------------------------------------------
// Wait-time divider
// Restoring divider, one quotient bit per cycle. Divides the 32-bit
// product by the division times 1000 in a single 32-step pass.
// ----------------------------------------------------------------------------
module mfdep_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfdep_pkg::div_req_t req_i,
  output mfdep_pkg::div_rsp_t rsp_o
);
  import mfdep_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_DONE
  } state_e;

  state_e      state_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q;
  logic [31:0] rem_q;
  logic [24:0] dsr_q;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    shifted = {rem_q[30:0], quo_q[31]};
    trial   = {1'b0, shifted} - {8'd0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            quo_q   <= req_i.dividend;
            rem_q   <= '0;
            dsr_q   <= req_i.divisor;
            cnt_q   <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          // one restoring step
          if (!trial[32]) begin
            rem_q <= trial[31:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= shifted;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= S_DONE;
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.busy     = (state_q != S_IDLE);
  assign rsp_o.done     = (state_q == S_DONE);
  assign rsp_o.quotient = quo_q;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// MIDI file drum event parser testbench
// Streams well-formed and broken MIDI files through the parser under varied
// idling, predicts every hit, wait, song end and format error in step with
// the input, and compares each output word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import mfdep_pkg::*;

  // Parser states of the predictor
  typedef enum logic [4:0] {
    P_HDR_TAG, P_HDR_LEN, P_HDR_FMT, P_HDR_NTRK, P_HDR_DIV, P_HDR_SKIP,
    P_TRK_TAG, P_TRK_LEN, P_DELTA, P_EVENT, P_DATA1, P_DATA2, P_META_TYPE,
    P_LEN_SKIP, P_LEN_TEMPO, P_SKIP, P_TEMPO, P_EOT_LEN, P_DONE
  } pstate_e;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [31:0] wait_ms;
    logic        frames;
  } event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  midi_file_drum_event_parser dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  in_word_t pending_bytes[$];
  event_t   expected_events[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_off = 0;   // receiver hold-off length, counted below
  bit       hold_busy = 0;
  bit       hold_start = 0;
  bit       took_word = 0;

  // Predictor state
  logic [3:0]  m_drum;
  pstate_e     m_st;
  logic [31:0] m_shift;
  logic [27:0] m_left;
  logic [31:0] m_delta;
  logic [31:0] m_tempo;
  logic [14:0] m_div;
  logic        m_frames;
  logic [15:0] m_ntrk;
  logic [15:0] m_seen;
  logic [7:0]  m_rs;
  logic [8:0]  m_held;
  logic [2:0]  m_cnt;

  function automatic void clear_parser();
    m_st = P_HDR_TAG; m_shift = '0; m_left = '0; m_delta = '0;
    m_tempo = TempoReset; m_div = DivisionReset; m_frames = 1'b0;
    m_ntrk = '0; m_seen = '0; m_rs = '0; m_held = '0; m_cnt = '0;
  endfunction

  function automatic void push_event(kind_e k, logic [7:0] n, logic [7:0] v,
                                     logic [31:0] w);
    event_t e;
    e.kind = k; e.note = n; e.vel = v; e.wait_ms = w; e.frames = m_frames;
    expected_events.push_back(e);
  endfunction

  // Shift a byte into a fixed field; true once n bytes are in
  function automatic bit shift_fixed(logic [7:0] b, int n);
    m_shift = {m_shift[23:0], b};
    m_cnt = m_cnt + 3'd1;
    if (m_cnt >= n) begin
      m_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit short_msg();
    return m_rs[7:4] == 4'hC || m_rs[7:4] == 4'hD;
  endfunction

  function automatic void to_delta();
    m_delta = '0;
    m_st = P_DELTA;
  endfunction

  function automatic void predict_word(in_word_t w);
    logic [7:0]  b;
    logic [31:0] v;
    logic [31:0] prod;
    logic [31:0] wt;
    b = w.data;
    if (w.cmd == CMD_RESTART) begin
      clear_parser();
      return;
    end
    case (m_st)
      P_HDR_TAG, P_TRK_TAG: begin
        if (shift_fixed(b, 4)) begin
          v = m_shift; m_shift = '0;
          if (m_st == P_HDR_TAG && v == TagHeader) m_st = P_HDR_LEN;
          else if (m_st == P_TRK_TAG && v == TagTrack) begin
            if (m_seen != 16'hFFFF) m_seen++;
            m_rs = '0; m_held = '0; m_st = P_TRK_LEN;
          end else begin
            m_st = P_DONE;
            push_event(KIND_ERROR, 0, 0, 0);
          end
        end
      end
      P_HDR_LEN: if (shift_fixed(b, 4)) begin
        v = m_shift; m_shift = '0;
        v = (v > 6) ? v - 6 : 0;
        m_left = (v > {4'h0, Mask28}) ? Mask28 : v[27:0];
        m_st = P_HDR_FMT;
      end
      P_HDR_FMT: if (shift_fixed(b, 2)) begin
        m_shift = '0; m_st = P_HDR_NTRK;
      end
      P_HDR_NTRK: if (shift_fixed(b, 2)) begin
        m_ntrk = m_shift[15:0]; m_shift = '0; m_st = P_HDR_DIV;
      end
      P_HDR_DIV: if (shift_fixed(b, 2)) begin
        m_frames = m_shift[15]; m_div = m_shift[14:0]; m_shift = '0;
        m_st = (m_left != 0) ? P_HDR_SKIP : P_TRK_TAG;
      end
      P_HDR_SKIP: begin
        m_left = m_left - 1;
        if (m_left == 0) m_st = P_TRK_TAG;
      end
      P_TRK_LEN: if (shift_fixed(b, 4)) begin
        m_shift = '0; to_delta();
      end
      P_DELTA: begin
        m_delta = {m_delta[24:0], b[6:0]};
        if (!b[7]) begin
          m_st = P_EVENT;
          if (m_delta != 0) begin
            prod = m_tempo * m_delta;
            wt = (m_div != 0) ? prod / m_div / 1000 : 0;
            m_delta = '0;
            push_event(KIND_WAIT, 0, 0, wt);
          end
        end
      end
      P_EVENT: begin
        if (b == SysExStart || b == SysExEscape) begin
          m_shift = '0; m_st = P_LEN_SKIP;
        end else if (b == MetaStatus) m_st = P_META_TYPE;
        else if (b[7] && b < SysExStart) begin
          m_rs = b; m_held = '0; m_st = P_DATA1;
        end else if (!b[7] && m_rs != 0) begin
          if (short_msg()) to_delta();
          else begin
            m_held = {1'b1, b}; m_st = P_DATA2;
          end
        end
      end
      P_DATA1: begin
        if (short_msg()) to_delta();
        else begin
          m_held = {1'b1, b}; m_st = P_DATA2;
        end
      end
      P_DATA2: begin
        to_delta();
        if (m_rs[7:4] == NoteOnHi && m_rs[3:0] == m_drum && b != 0)
          push_event(KIND_HIT, m_held[7:0], b, 0);
      end
      P_META_TYPE: begin
        m_shift = '0;
        if (b == MetaEndTrack) begin
          if (m_seen >= m_ntrk) begin
            m_st = P_DONE;
            push_event(KIND_END, 0, 0, 0);
          end else m_st = P_EOT_LEN;
        end else m_st = (b == MetaTempo) ? P_LEN_TEMPO : P_LEN_SKIP;
      end
      P_LEN_SKIP, P_LEN_TEMPO: begin
        m_shift = {m_shift[24:0], b[6:0]};
        if (!b[7]) begin
          m_left = m_shift[27:0]; m_shift = '0;
          if (m_left != 0) m_st = (m_st == P_LEN_TEMPO) ? P_TEMPO : P_SKIP;
          else begin
            if (m_st == P_LEN_TEMPO) m_tempo = '0;
            to_delta();
          end
        end
      end
      P_SKIP: begin
        m_left = m_left - 1;
        if (m_left == 0) to_delta();
      end
      P_TEMPO: begin
        m_shift = {m_shift[23:0], b};
        m_left = m_left - 1;
        if (m_left == 0) begin
          m_tempo = m_shift; m_shift = '0; to_delta();
        end
      end
      P_EOT_LEN: begin
        m_cnt = '0; m_shift = '0; m_st = P_TRK_TAG;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders: append file bytes to the pending queue
  // ---------------------------------------------------------------------------
  task automatic put(logic [7:0] b);
    in_word_t w;
    w.cmd = CMD_BYTE; w.data = b;
    pending_bytes.push_back(w);
  endtask

  task automatic put_restart();
    in_word_t w;
    w.cmd = CMD_RESTART; w.data = 8'($urandom);
    pending_bytes.push_back(w);
  endtask

  task automatic put32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) put(v[i*8 +: 8]);
  endtask

  // Variable-length quantity, most significant group first
  task automatic put_vlq(logic [31:0] v, int groups);
    for (int i = groups - 1; i >= 0; i--)
      put({(i != 0), 7'((v >> (7 * i)) & 32'h7F)});
  endtask

  task automatic put_header(logic [15:0] ntrk, logic [15:0] div, int extra);
    put32(TagHeader);
    put32(32'd6 + extra);
    put(8'h00); put(8'($urandom_range(0, 2)));
    put(ntrk[15:8]); put(ntrk[7:0]);
    put(div[15:8]); put(div[7:0]);
    repeat (extra) put(8'($urandom));
  endtask

  task automatic put_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) put(8'h00);
    else if (r < 8) put_vlq($urandom_range(1, 127), 1);
    else if (r < 9) put_vlq($urandom_range(128, 16383), 2);
    else put_vlq($urandom, 5);   // overlong, wraps
  endtask

  // One random event after a delta
  task automatic put_event(logic [3:0] drum);
    int r;
    logic [7:0] st;
    r = $urandom_range(0, 19);
    if (r < 7) begin
      st = {NoteOnHi, ($urandom_range(0, 2) == 0) ? 4'($urandom) : drum};
      put(st); put(8'($urandom) & 8'h7F);
      put(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
    end else if (r < 9) begin
      put(8'($urandom) & 8'h7F);   // running status
      if ($urandom_range(0, 1)) put(8'($urandom_range(0, 127)));
    end else if (r < 12) begin
      st = 8'($urandom_range(8'h80, 8'hEF));
      put(st); put(8'($urandom) & 8'h7F);
      if (!(st[7:4] == 4'hC || st[7:4] == 4'hD)) put(8'($urandom) & 8'h7F);
    end else if (r < 14) begin
      put(MetaStatus); put(MetaTempo);
      if ($urandom_range(0, 4) == 0) put(8'h00);
      else begin
        int n;
        n = $urandom_range(1, 5);
        put_vlq(n, 1);
        repeat (n) put(8'($urandom));
      end
    end else if (r < 16) begin
      int n;
      logic [7:0] mt;
      mt = 8'($urandom_range(0, 8'h7F));
      put(MetaStatus); put((mt == MetaEndTrack) ? 8'h01 : mt);
      n = $urandom_range(0, 4);
      put_vlq(n, $urandom_range(1, 2));
      repeat (n) put(8'($urandom));
    end else if (r < 18) begin
      int n;
      put(($urandom_range(0, 1)) ? SysExStart : SysExEscape);
      n = $urandom_range(0, 5);
      put_vlq(n, $urandom_range(1, 2));
      repeat (n) put(8'($urandom));
    end else begin
      put(8'($urandom_range(8'hF1, 8'hFE)) | 8'h00);   // stray status or escape
    end
  endtask

  task automatic put_track(int events, logic [3:0] drum);
    put32(TagTrack);
    put32($urandom);
    repeat (events) begin
      put_delta();
      put_event(drum);
    end
    put_delta();
    put(MetaStatus); put(MetaEndTrack); put(8'h00);
  endtask

  task automatic put_song(logic [3:0] drum);
    int ntrk;
    logic [15:0] div;
    ntrk = $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0:       div = 16'h0000;
      1:       div = 16'h8000 | 16'($urandom);
      2:       div = 16'h7FFF;
      default: div = 16'($urandom_range(24, 960));
    endcase
    put_header(16'(ntrk), div,
               ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    for (int t = 0; t < ((ntrk == 0) ? 1 : ntrk); t++)
      put_track($urandom_range(2, 10), drum);
    put_restart();
  endtask

  // Broken file: a corrupted track tag after a header, a corrupted header tag, or plain noise
  task automatic put_broken();
    case ($urandom_range(0, 2))
      0: begin
        put_header(16'd1, 16'd480, 0);
        put32(TagTrack ^ (32'h1 << $urandom_range(0, 31)));
      end
      1: begin
        put32(TagHeader ^ (32'h1 << $urandom_range(0, 31)));
        repeat ($urandom_range(0, 4)) put(8'($urandom));
      end
      default: repeat ($urandom_range(5, 20)) put(8'($urandom));
    endcase
    put_restart();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending words; change at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || took_word) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_word_t w;
          w = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.data;
          s_axis_tuser  <= w.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (hold_off > 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Receiver hold-off: count the long back-pressure stretch down
  always @(posedge clk_i) begin
    if (hold_start && !hold_busy) begin
      hold_busy <= 1'b1;
      hold_off  <= 2000;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted input word, check each output word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    took_word <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_word_t w;
        w.cmd = s_axis_tuser; w.data = s_axis_tdata;
        predict_word(w);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected output word kind=%0d data=%h", m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          event_t e;
          e = expected_events.pop_front();
          if (m_axis_tuser != e.kind) begin
            $error("kind: expected %0d got %0d", e.kind, m_axis_tuser); errors++;
          end
          if (m_axis_tdata[7:0] != e.note) begin
            $error("note_number: expected %0d got %0d", e.note, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[15:8] != e.vel) begin
            $error("velocity: expected %0d got %0d", e.vel, m_axis_tdata[15:8]);
            errors++;
          end
          if (m_axis_tdata[47:16] != e.wait_ms) begin
            $error("wait_ms: expected %0d got %0d", e.wait_ms, m_axis_tdata[47:16]);
            errors++;
          end
          if (m_axis_tdata[48] != e.frames) begin
            $error("frame_mode: expected %0d got %0d", e.frames, m_axis_tdata[48]);
            errors++;
          end
        end
      end
    end
  end

  // Wait until every queued word is sent and every result has arrived
  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Write the drum channel while the parser is idle
  task automatic set_drum(logic [3:0] ch);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= ch;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    m_drum = ch;
  endtask

  initial begin
    int phase_pct[4][2];
    logic [3:0] drum_list[4];
    phase_pct = '{'{0, 0}, '{47, 0}, '{0, 47}, '{14, 14}};
    drum_list = '{4'd0, 4'd15, 4'd9, 4'd5};
    m_drum = DrumChanReset;
    clear_parser();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: header extremes, tempo forms, several event kinds, bad tags
    put_header(16'd1, 16'd0, 0);              // division zero gives wait 0
    put_track(0, 4'd9);
    put32(TagTrack);                          // resting: ignored
    put_restart();
    put_header(16'd0, 16'hE728, 2);           // frames mode, long header
    put32(TagTrack); put32(0);
    put(8'h00); put(MetaStatus); put(MetaTempo); put(8'h00);     // tempo 0
    put(8'h81); put(8'h00); put(8'h99); put(8'h24); put(8'h7F);  // hit
    put(8'h00); put(MetaStatus); put(MetaTempo); put(8'h05);
    put32(32'hFFFFFFFF); put(8'hAA);          // long tempo keeps low bytes
    put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F); put(8'h40); put(8'h00);
    put(8'h00); put(8'h42);                   // running status, zero velocity
    put(8'h00); put(8'hF5); put(8'h55);       // its zero velocity, then F5 55 taken as a delta
    put(8'h00); put(MetaStatus); put(MetaEndTrack); put(8'h00);
    put_restart();
    put32(TagHeader ^ 32'h80000000);          // bad header tag
    put_restart();
    put32(TagHeader); put32(32'hFFFFFFFF);    // saturated header length
    put_restart();
    put_header(16'hFFFF, 16'd480, 0);
    put32(TagTrack); put32(0);
    put(8'h00); put(SysExStart); put_vlq(32'h90, 2); repeat (32'h90) put(8'h00);
    put(8'h00); put(MetaStatus); put(MetaEndTrack); put(8'h00);
    put32(TagTrack ^ 32'h1);
    put_restart();
    drain();

    for (int p = 0; p < 4; p++) begin
      set_drum(drum_list[p]);
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      if (p == 2) hold_start = 1'b1;           // long back-pressure stretch
      while (pending_bytes.size() < 260) begin
        if ($urandom_range(0, 5) == 0) put_broken();
        else put_song(drum_list[p]);
      end
      drain();
    end

    if (errors == 0) $display("** midi_file_drum_event_parser: PASSED **");
    else $display("** midi_file_drum_event_parser: FAILED **");
    $finish;
  end

  initial begin
    #20000000;
    $display("** midi_file_drum_event_parser: FAILED **");
    $finish;
  end

endmodule
